/* design/cam_pkg.sv */
// Shared types and constants for the cartridge address map decoder.
// No dependencies; every other design file imports this package.

package cam_pkg;

    // Target codes of a decoded access.
    localparam logic [2:0] TGT_NONE  = 3'd0;
    localparam logic [2:0] TGT_ROM   = 3'd1;
    localparam logic [2:0] TGT_WRAM  = 3'd2;
    localparam logic [2:0] TGT_SRAM  = 3'd3;
    localparam logic [2:0] TGT_VIDEO = 3'd4;
    localparam logic [2:0] TGT_IO    = 3'd5;
    localparam logic [2:0] TGT_JOY   = 3'd6;
    localparam logic [2:0] TGT_BAD   = 3'd7;

    // Access kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_LOROM_MODE = 1'b0;
    localparam logic CFG_SRAM_SIZE  = 1'b1;

    // Access speeds in master clocks.
    localparam logic [3:0] CYC_FAST = 4'd6;
    localparam logic [3:0] CYC_SLOW = 4'd8;

    // Work RAM spans two full banks.
    localparam int WRAM_ADDR_BITS = 17;

    // Bank numbers and address ranges used by the map.
    localparam logic [7:0]  BANK_SRAM_LO  = 8'h70;
    localparam logic [7:0]  BANK_SRAM_HI  = 8'h71;
    localparam logic [7:0]  BANK_WRAM_LO  = 8'h7E;
    localparam logic [7:0]  BANK_WRAM_HI  = 8'h7F;
    localparam logic [7:0]  BANK_OPEN     = 8'h60;
    localparam logic [7:0]  BANK_RO_FIRST = 8'hD0;
    localparam logic [7:0]  BANK_RO_LAST  = 8'hFE;
    localparam logic [23:0] ADDR_HI_LO    = 24'hC00000;
    localparam logic [23:0] ADDR_HI_END   = 24'hFE0000;
    localparam logic [23:0] ADDR_MID_LO   = 24'h710000;
    localparam logic [23:0] ADDR_MID_END  = 24'h7E0000;
    localparam logic [15:0] JOYPAD_PORT   = 16'h4016;

    typedef struct packed {
        logic        req_type;
        logic [23:0] bus_address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [21:0] target_offset;
        logic [7:0]  data;
        logic [3:0]  access_cycles;
    } resp_t;

    typedef struct packed {
        logic       lorom_mode;
        logic [2:0] sram_size_code;
    } cfg_t;

endpackage

/* design/cam_decode.sv */
// Combinational address map decode for one bus access.
// Depends on cam_pkg for the request, response and configuration types.

module cam_decode
    import cam_pkg::*;
#(
    parameter int ROM_ADDR_BITS = 22
) (
    input  req_t  req,
    input  cfg_t  cfg,
    output resp_t resp
);

    localparam logic [21:0] ROM_MASK = 22'((64'd1 << ROM_ADDR_BITS) - 64'd1);
    localparam logic [21:0] WRAM_MASK = 22'((64'd1 << WRAM_ADDR_BITS) - 64'd1);

    logic [23:0] a;
    logic [7:0]  bank;
    logic [6:0]  low_bank;
    logic [2:0]  page;
    logic [15:0] reg_addr;
    logic [3:0]  sel;
    logic        wr;
    logic        lo;
    logic        sys;
    logic        io_page;
    logic [17:0] sram_mask_wide;
    logic [21:0] sram_mask;
    logic [21:0] sram_off;
    logic [21:0] lorom_off;
    logic [7:0]  dv;

    always_comb begin
        a        = req.bus_address;
        bank     = a[23:16];
        low_bank = a[22:16];
        page     = a[15:13];
        reg_addr = a[15:0];
        sel      = a[15:12];
        wr       = (req.req_type == REQ_WRITE);
        lo       = cfg.lorom_mode;
        // System banks are 00-3F and their mirror 80-BF.
        sys      = !low_bank[6];
        // Pages 1 to 3 of the system banks hold the register and expansion area.
        io_page  = sys && (page >= 3'd1) && (page <= 3'd3);
        dv       = wr ? req.write_data : 8'h00;

        if (cfg.sram_size_code == 3'd0) begin
            sram_mask_wide = '0;
        end else begin
            sram_mask_wide = (18'd1 << (5'(cfg.sram_size_code) + 5'd10)) - 18'd1;
        end
        sram_mask = {4'd0, sram_mask_wide};
        sram_off  = a[21:0] & sram_mask;
        lorom_off = {low_bank, a[14:0]} & ROM_MASK;
    end

    always_comb begin
        resp.access_cycles = io_page ? CYC_FAST : CYC_SLOW;
        resp.target        = TGT_NONE;
        resp.target_offset = '0;
        resp.data          = dv;

        if (sys && page == 3'd0) begin
            resp.target        = TGT_WRAM;
            resp.target_offset = {9'd0, a[12:0]};
        end else if (bank == BANK_WRAM_LO || bank == BANK_WRAM_HI) begin
            resp.target        = TGT_WRAM;
            resp.target_offset = a[21:0] & WRAM_MASK;
        end else if (!lo && (bank == BANK_SRAM_LO || bank == BANK_SRAM_HI)) begin
            resp.target        = TGT_SRAM;
            resp.target_offset = {9'd0, a[12:0]};
        end else if (!wr && lo && a[15] && low_bank < 7'h60) begin
            resp.target        = TGT_ROM;
            resp.target_offset = lorom_off;
        end else if (!wr && !lo && !io_page) begin
            resp.target        = TGT_ROM;
            resp.target_offset = a[21:0] & ROM_MASK;
        end else if (!wr) begin
            // Reads that miss the page map.
            if (sys) begin
                case (sel)
                    4'h2: begin
                        resp.target        = TGT_VIDEO;
                        resp.target_offset = {6'd0, reg_addr};
                    end
                    4'h4: begin
                        if (a[11:9] == 3'b001) begin
                            resp.target        = TGT_IO;
                            resp.target_offset = {6'd0, reg_addr};
                        end else if (reg_addr[15:1] == JOYPAD_PORT[15:1]) begin
                            resp.target        = TGT_JOY;
                            resp.target_offset = {6'd0, reg_addr};
                        end
                    end
                    4'h6, 4'h7: begin
                        if (!lo) begin
                            resp.target        = TGT_SRAM;
                            resp.target_offset = sram_off;
                        end else begin
                            resp.data = 8'hFF;
                        end
                    end
                    default: begin
                        resp.data = 8'hFF;
                    end
                endcase
            end else if (bank == BANK_SRAM_LO && sram_mask != '0) begin
                resp.target        = TGT_SRAM;
                resp.target_offset = sram_off;
            end
        end else if (sys) begin
            // Writes into the system banks.
            case (sel)
                4'h2: begin
                    if (a[11:8] == 4'h1) begin
                        resp.target        = TGT_VIDEO;
                        resp.target_offset = {6'd0, reg_addr};
                    end
                end
                4'h4: begin
                    if (a[11:9] == 3'b001) begin
                        resp.target        = TGT_IO;
                        resp.target_offset = {6'd0, reg_addr};
                    end else if (reg_addr[15:1] == JOYPAD_PORT[15:1]) begin
                        resp.target        = TGT_JOY;
                        resp.target_offset = {6'd0, reg_addr};
                    end
                end
                4'h6, 4'h7: begin
                    if (!lo) begin
                        resp.target        = TGT_SRAM;
                        resp.target_offset = sram_off;
                    end
                end
                4'h0, 4'h1: begin
                    resp.target        = TGT_BAD;
                    resp.target_offset = a[21:0];
                end
                default: begin
                    resp.target = TGT_NONE;
                end
            endcase
        end else if (bank >= BANK_RO_FIRST && bank <= BANK_RO_LAST) begin
            resp.target = TGT_NONE;
        end else if (bank == BANK_SRAM_LO) begin
            resp.target        = TGT_SRAM;
            resp.target_offset = sram_off;
        end else if (bank == BANK_OPEN
                     || (a >= ADDR_HI_LO && a < ADDR_HI_END)
                     || (a >= ADDR_MID_LO && a < ADDR_MID_END)) begin
            resp.target = TGT_NONE;
        end else begin
            resp.target        = TGT_BAD;
            resp.target_offset = a[21:0];
        end
    end

endmodule

/* design/cartridge_address_map_decoder.sv */
// Top level of the cartridge address map decoder: configuration registers and
// a two-register pipeline around cam_decode. Depends on cam_pkg and cam_decode.
//
// Each bus access enters on the s_ channel (req_type, bus_address, write_data)
// and leaves on the m_ channel as target, target_offset, data and
// access_cycles. Both channels use valid/ready; one transfer moves one access.
// The access is captured in an input register, decoded by a short
// combinational map, and captured in a result register. One access is taken
// every cycle while the receiver accepts results; a single decode stage lies
// between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills behind it, and s_ready drops once both are occupied; the flow picks up
// again in the cycle m_ready returns.
// Configuration is a plain write port: cfg_wr_en with cfg_index 0 writes
// lorom_mode, index 1 writes sram_size_code. Writes take effect at once and
// belong in idle periods. Synchronous active-low reset empties both pipeline
// registers and sets lorom_mode to 1 and sram_size_code to 0.

module cartridge_address_map_decoder
    import cam_pkg::*;
#(
    parameter int ROM_ADDR_BITS = 22
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [2:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  req_t       s_req,
    output logic       m_valid,
    input  logic       m_ready,
    output resp_t      m_resp
);

    cfg_t  cfg_reg;
    logic  in_valid_reg;
    req_t  in_req_reg;
    logic  out_valid_reg;
    resp_t out_resp_reg;
    resp_t dec_resp;
    logic  out_ready;
    logic  in_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_ready   = in_ready;
    assign m_valid   = out_valid_reg;
    assign m_resp    = out_resp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lorom_mode     <= 1'b1;
            cfg_reg.sram_size_code <= 3'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOROM_MODE: cfg_reg.lorom_mode     <= cfg_wdata[0];
                CFG_SRAM_SIZE:  cfg_reg.sram_size_code <= cfg_wdata;
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            in_req_reg <= s_req;
        end
        if (out_ready && in_valid_reg) begin
            out_resp_reg <= dec_resp;
        end
    end

    cam_decode #(
        .ROM_ADDR_BITS(ROM_ADDR_BITS)
    ) u_decode (
        .req (in_req_reg),
        .cfg (cfg_reg),
        .resp(dec_resp)
    );

endmodule

/* design/cam_checker.sv */
// Port-level checks for the cartridge address map decoder, bound to the top.
// Depends on cam_pkg for the payload types and target codes.

module cam_checker
    import cam_pkg::*;
(
    input logic  aclk,
    input logic  aresetn,
    input logic  s_ready,
    input logic  m_valid,
    input logic  m_ready,
    input resp_t m_resp
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result transfer holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_resp))
        else $error("stalled result changed");

    // Access speed is always one of the two bus speeds.
    a_cycles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_resp.access_cycles == CYC_FAST
                     || m_resp.access_cycles == CYC_SLOW))
        else $error("bad access speed");

    // Constant and ignored accesses carry a zero offset.
    a_none_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_resp.target == TGT_NONE |-> m_resp.target_offset == '0)
        else $error("nonzero offset on constant target");

    // With the receiver ready, the input side is never stalled.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output ready");

endmodule

bind cartridge_address_map_decoder cam_checker u_cam_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_resp (m_resp)
);
